### rtl/atnp_pkg.sv
// Package for the ARM/Thumb next-PC unit: opcodes, state codes, tables and helpers.
// No dependencies.
`default_nettype none
package atnp_pkg;

  localparam int unsigned NumRegs = 17;
  localparam logic [4:0]  PcIdx   = 5'd15;
  localparam logic [4:0]  CpsrIdx = 5'd16;
  localparam logic [4:0]  SpIdx   = 5'd13;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpEval  = 2'd1,
    OpData  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PendNone  = 2'd0,
    PendLdr   = 2'd1,
    PendLdm   = 2'd2,
    PendPop   = 2'd3
  } pend_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdA,
    StRdB,
    StRdC,
    StCalc,
    StOut,
    StIssue
  } state_e;

  // Condition pass table indexed by cond, bit selected by NZCV.
  function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] nzcv);
    logic [15:0] t;
    begin
      unique case (cond)
        4'h0: t = 16'hF0F0;
        4'h1: t = 16'h0F0F;
        4'h2: t = 16'hCCCC;
        4'h3: t = 16'h3333;
        4'h4: t = 16'hFF00;
        4'h5: t = 16'h00FF;
        4'h6: t = 16'hAAAA;
        4'h7: t = 16'h5555;
        4'h8: t = 16'h0C0C;
        4'h9: t = 16'hF3F3;
        4'hA: t = 16'hAA55;
        4'hB: t = 16'h55AA;
        4'hC: t = 16'h0A05;
        4'hD: t = 16'hF5FA;
        4'hE: t = 16'hFFFF;
        default: t = 16'h0000;
      endcase
      return t[nzcv];
    end
  endfunction

  // Unconditional-space instructions that run even when cond 15 fails.
  function automatic logic unc_hit(input logic [31:0] ins);
    begin
      return ((ins & 32'hFD500000) == 32'hF5500000)
          || ((ins & 32'hFE000000) == 32'hFA000000)
          || ((ins & 32'hFE100000) == 32'hFC000000)
          || ((ins & 32'hFE100000) == 32'hFC100000)
          || ((ins & 32'hFE000001) == 32'hFE000000)
          || ((ins & 32'hFE100001) == 32'hFE100000);
    end
  endfunction

  function automatic logic [4:0] popcnt16(input logic [15:0] v);
    logic [4:0] n;
    begin
      n = '0;
      for (int i = 0; i < 16; i++) n = n + {4'd0, v[i]};
      return n;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/atnp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module atnp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/arm_thumb_next_pc_unit.sv
// Top level of the ARM/Thumb next-PC unit: register file RAM plus sequencer.
// Depends on atnp_pkg and atnp_ram.
// Timing: register writes and data returns are registered; an evaluate makes five reads
// (CPSR, PC, two operands, Rs) through the one RAM read port, then issues its result.
// Throughput: one item at a time; input is taken only in the idle state with no result held.
// Reset clears the sequencer, output valid and the pending load; registers stay undefined.
`default_nettype none
module arm_thumb_next_pc_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [1:0] opcode, [6:2] reg_index, [38:7] data_value, [70:39] instr_word, zero pad
  input  wire logic [71:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_value
  output      logic [31:0] m_axis_tdata,
  // [0] result_kind
  output      logic        m_axis_tuser
);
  // Input fields
  logic [1:0]  op;
  logic [4:0]  idx;
  logic [31:0] dat, ins_in;
  assign op     = s_axis_tdata[1:0];
  assign idx    = s_axis_tdata[6:2];
  assign dat    = s_axis_tdata[38:7];
  assign ins_in = s_axis_tdata[70:39];

  atnp_pkg::state_e state_q, state_d;
  logic [1:0]  pend_q, pend_d;
  logic [31:0] ins_q, ins_d;
  logic [31:0] cpsr_q, cpsr_d, pc_q, pc_d, ra_q, ra_d, rb_q, rb_d;
  logic        ovld_q, ovld_d;
  logic [31:0] oval_q, oval_d;
  logic        okind_q, okind_d;

  logic        we;
  logic [4:0]  raddr;
  logic [31:0] rdata;

  atnp_ram #(.Width(32), .Depth(atnp_pkg::NumRegs)) u_rf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(idx),
    .wdata_i(dat),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == atnp_pkg::StIdle) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = oval_q;
  assign m_axis_tuser  = okind_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign we  = acc && (op == atnp_pkg::OpWrite) && (idx < 5'(atnp_pkg::NumRegs));

  // Operand register numbers chosen from the instruction.
  logic        thumb;
  logic [3:0]  sel_a, sel_b;
  assign thumb = cpsr_q[5];
  always_comb begin
    if (thumb) begin
      sel_a = (ins_q[15:12] == 4'hB) ? 4'd13 : ins_q[6:3];
      sel_b = ins_q[6:3];
    end else if (ins_q[27:24] == 4'h1 || ins_q[27:24] == 4'h0 ||
                 ins_q[27:24] == 4'h2 || ins_q[27:24] == 4'h3) begin
      // BX forms read Rm; data processing reads Rn
      sel_a = (ins_q[23:4] == 20'h2FFF1 || ins_q[23:4] == 20'h2FFF2 ||
               ins_q[23:4] == 20'h2FFF3) ? ins_q[3:0] : ins_q[19:16];
      sel_b = ins_q[3:0];
    end else begin
      sel_a = ins_q[19:16];
      sel_b = ins_q[3:0];
    end
  end

  // Low byte of Rs, captured in StOut
  logic [31:0] rs_q, rs_d;

  // Next-PC calculation from captured registers.
  logic [31:0] pc, a, b, rs, shv, sho, imm, dp, res;
  logic [1:0]  kind;
  logic        c;
  logic [7:0]  sh;
  logic        sh_big;
  logic [4:0]  rot;
  always_comb begin
    pc  = pc_q;
    c   = cpsr_q[29];
    a   = (ins_q[19:16] == 4'd15) ? pc + 32'd8 : ra_q;
    rs  = (ins_q[11:8] == 4'd15) ? pc + 32'd8 : rs_q;
    shv = (ins_q[3:0] == 4'd15) ? pc + (ins_q[4] ? 32'd12 : 32'd8) : rb_q;
    sh  = ins_q[4] ? rs[7:0] : {3'd0, ins_q[11:7]};
    // Shift amount of 32 or more, including a full PC value as Rs
    sh_big = (sh >= 8'd32) || (ins_q[4] && ins_q[11:8] == 4'd15 && rs[31:8] != '0);
    case (ins_q[6:5])
      2'd0: sho = sh_big ? 32'd0 : shv << sh[4:0];
      2'd1: sho = sh_big ? 32'd0 : shv >> sh[4:0];
      2'd2: sho = $signed(shv) >>> (sh_big ? 5'd31 : sh[4:0]);
      default: begin
        if (sh[4:0] == 5'd0) sho = {c, shv[31:1]};
        else sho = (shv >> sh[4:0]) | (shv << (6'd32 - {1'b0, sh[4:0]}));
      end
    endcase
    rot = {ins_q[11:8], 1'b0};
    imm = ({24'd0, ins_q[7:0]} >> rot) | ({24'd0, ins_q[7:0]} << (6'd32 - {1'b0, rot}));
    if (rot == 5'd0) imm = {24'd0, ins_q[7:0]};
    b = ins_q[25] ? imm : sho;
    case (ins_q[24:21])
      4'h0: dp = a & b;
      4'h1: dp = a ^ b;
      4'h2: dp = a - b;
      4'h3: dp = b - a;
      4'h4: dp = a + b;
      4'h5: dp = a + b + {31'd0, c};
      4'h6: dp = a - b + {31'd0, c};
      4'h7: dp = b - a + {31'd0, c};
      4'hC: dp = a | b;
      4'hD: dp = b;
      4'hE: dp = a & ~b;
      4'hF: dp = ~b;
      default: dp = pc + 32'd4;
    endcase

    kind = atnp_pkg::PendNone;
    res  = '0;
    if (thumb) begin
      res = pc + 32'd2;
      if (ins_q[15:13] == 3'd7 && ins_q[12:11] != 2'd0) begin
        res = pc + 32'd4;
      end else begin
        case (ins_q[15:12])
          4'h4: begin
            if (ins_q[11:8] == 4'd7) begin
              res = (ins_q[6:3] == 4'd15) ? pc + 32'd4 : rb_q;
            end else if (ins_q[7] && (ins_q[11:0] & 12'hC07) == 12'h407) begin
              if (ins_q[9:8] == 2'd0)
                res = pc + 32'd4 + ((ins_q[6:3] == 4'd15) ? pc + 32'd4 : rb_q);
              else if (ins_q[9:8] == 2'd2)
                res = (ins_q[6:3] == 4'd15) ? pc + 32'd4 : rb_q;
            end
          end
          4'hB: begin
            if (ins_q[11:8] == 4'hD) begin
              kind = atnp_pkg::PendPop;
              res  = ra_q + {25'd0, atnp_pkg::popcnt16({8'd0, ins_q[7:0]}), 2'd0};
            end
          end
          4'hD: begin
            if (ins_q[11:8] != 4'd15 && atnp_pkg::cond_pass(ins_q[11:8], cpsr_q[31:28]))
              res = pc + 32'd4 + {{23{ins_q[7]}}, ins_q[7:0], 1'b0};
          end
          4'hE: begin
            if (!ins_q[11]) res = pc + 32'd4 + {{20{ins_q[10]}}, ins_q[10:0], 1'b0};
          end
          default: ;
        endcase
      end
      if (kind == atnp_pkg::PendNone) res[0] = 1'b0;
    end else begin
      res = pc + 32'd4;
      if (atnp_pkg::cond_pass(ins_q[31:28], cpsr_q[31:28]) ||
          (ins_q[31:28] == 4'hF && atnp_pkg::unc_hit(ins_q))) begin
        case (ins_q[27:24])
          4'h0, 4'h1, 4'h2, 4'h3: begin
            if (ins_q[27:24] == 4'h1 && ins_q[4] && ins_q[7] && ins_q[20] &&
                ins_q[6:5] != 2'd0 && ins_q[15:12] == 4'd15) begin
              res = pc + 32'd4;
            end else if (ins_q[15:12] != 4'd15) begin
              res = pc + 32'd4;
            end else if (ins_q[25:22] == 4'd0 && ins_q[7:4] == 4'd9) begin
              res = pc + 32'd4;
            end else if (ins_q[23:4] == 20'h2FFF1 || ins_q[23:4] == 20'h2FFF2 ||
                         ins_q[23:4] == 20'h2FFF3) begin
              res = ((ins_q[3:0] == 4'd15) ? pc + 32'd8 : ra_q) & ~32'd1;
            end else begin
              res = dp;
            end
          end
          4'h4, 4'h5, 4'h6, 4'h7: begin
            if (ins_q[20] && ins_q[15:12] == 4'd15 && !ins_q[22]) begin
              logic [31:0] off;
              off  = ins_q[25] ? sho : {20'd0, ins_q[11:0]};
              if (!ins_q[23]) off = 32'd0 - off;
              res  = ins_q[24] ? a + off : a;
              kind = atnp_pkg::PendLdr;
            end
          end
          4'h8, 4'h9: begin
            if (ins_q[20] && ins_q[15]) begin
              logic [31:0] off;
              off = '0;
              if (ins_q[23]) begin
                off = {25'd0, atnp_pkg::popcnt16({1'b0, ins_q[14:0]}), 2'd0};
                if (ins_q[24]) off = off + 32'd4;
              end else if (ins_q[24]) begin
                off = 32'hFFFFFFFC;
              end
              res  = ra_q + off;
              kind = atnp_pkg::PendLdm;
            end
          end
          4'hA, 4'hB: begin
            res = pc + 32'd8 + {{6{ins_q[23]}}, ins_q[23:0], 2'b00};
            if (ins_q[31:28] == 4'hF) res = res + {30'd0, ins_q[24], 1'b0};
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer: read CPSR, PC, A, B, Rs, then issue the result; data returns are answered in idle.
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    ins_d   = ins_q;
    cpsr_d  = cpsr_q;
    pc_d    = pc_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    rs_d    = rs_q;
    ovld_d  = ovld_q && !m_axis_tready;
    oval_d  = oval_q;
    okind_d = okind_q;
    raddr   = atnp_pkg::CpsrIdx;
    unique case (state_q)
      atnp_pkg::StIdle: begin
        raddr = atnp_pkg::CpsrIdx;
        if (acc) begin
          case (op)
            atnp_pkg::OpEval: begin
              ins_d   = ins_in;
              state_d = atnp_pkg::StRdA;
            end
            atnp_pkg::OpData: begin
              if (pend_q != atnp_pkg::PendNone) begin
                ovld_d  = 1'b1;
                okind_d = 1'b0;
                case (pend_q)
                  atnp_pkg::PendLdr: oval_d = dat & 32'hFFFFFFFC;
                  atnp_pkg::PendPop: oval_d = dat & ~32'd1;
                  default:           oval_d = dat;
                endcase
                pend_d = atnp_pkg::PendNone;
              end
            end
            default: ;
          endcase
        end
      end
      atnp_pkg::StRdA: begin
        // CPSR arrives now; request PC
        raddr   = atnp_pkg::PcIdx;
        cpsr_d  = rdata;
        state_d = atnp_pkg::StRdB;
      end
      atnp_pkg::StRdB: begin
        pc_d    = rdata;
        raddr   = {1'b0, sel_a};
        state_d = atnp_pkg::StRdC;
      end
      atnp_pkg::StRdC: begin
        ra_d    = rdata;
        raddr   = {1'b0, sel_b};
        state_d = atnp_pkg::StCalc;
      end
      atnp_pkg::StCalc: begin
        rb_d    = rdata;
        raddr   = {1'b0, ins_q[11:8]};
        state_d = atnp_pkg::StOut;
      end
      atnp_pkg::StOut: begin
        rs_d    = {24'd0, rdata[7:0]};
        state_d = atnp_pkg::StIssue;
      end
      atnp_pkg::StIssue: begin
        // Present the result and record any load it starts
        ovld_d  = 1'b1;
        oval_d  = res;
        okind_d = (kind != atnp_pkg::PendNone);
        pend_d  = kind;
        state_d = atnp_pkg::StIdle;
      end
      default: state_d = atnp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atnp_pkg::StIdle;
      pend_q  <= atnp_pkg::PendNone;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q   <= ins_d;
    cpsr_q  <= cpsr_d;
    pc_q    <= pc_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    rs_q    <= rs_d;
    oval_q  <= oval_d;
    okind_q <= okind_d;
  end
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for arm_thumb_next_pc_unit: drives register, evaluate and data-return items
// and checks each next-PC result against an in-bench predictor. Depends on atnp_pkg and arm_thumb_next_pc_unit.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } npc_t;

  localparam logic [15:0] COND_TBL [16] = '{
    16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333, 16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555,
    16'h0C0C, 16'hF3F3, 16'hAA55, 16'h55AA, 16'h0A05, 16'hF5FA, 16'hFFFF, 16'h0000
  };
  localparam logic [31:0] UNC_PAT [7] = '{32'hF5500000, 32'hFA000000, 32'hFC000000,
    32'hFC100000, 32'hFE000000, 32'hFE000000, 32'hFE100000};
  localparam logic [31:0] UNC_MSK [7] = '{32'hFD500000, 32'hFE000000, 32'hFE100000,
    32'hFE100000, 32'hFE000001, 32'hFE000001, 32'hFE000001};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Predictor state
  logic [31:0]     regs_m [17];
  atnp_pkg::pend_e pend_m = atnp_pkg::PendNone;
  npc_t            next_pc_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;

  arm_thumb_next_pc_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic cond_ok(logic [3:0] c);
    return COND_TBL[c][regs_m[atnp_pkg::CpsrIdx][31:28]];
  endfunction

  function automatic logic [31:0] shifted_op(logic [31:0] ins, logic [31:0] pc, logic carry);
    logic [3:0]  rm;
    logic [31:0] sh, v;
    rm = ins[3:0];
    if (ins[4]) begin
      sh = (ins[11:8] == 4'hF) ? pc + 32'd8 : {24'd0, regs_m[ins[11:8]][7:0]};
    end else begin
      sh = {27'd0, ins[11:7]};
    end
    v = (rm == 4'hF) ? pc + (ins[4] ? 32'd12 : 32'd8) : regs_m[rm];
    case (ins[6:5])
      2'd0: v = (sh >= 32) ? 32'd0 : v << sh[4:0];
      2'd1: v = (sh >= 32) ? 32'd0 : v >> sh[4:0];
      2'd2: begin
        if (sh >= 32) sh = 32'd31;
        v = $signed(v) >>> sh[4:0];
      end
      default: begin
        sh = sh & 32'd31;
        if (sh == 0) v = {carry, v[31:1]};
        else v = (v >> sh) | (v << (32 - sh));
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] alu_to_pc(logic [31:0] ins, logic [31:0] pc,
                                            logic [31:0] npc);
    logic [31:0] a, b, imm, c;
    logic [4:0]  rot;
    if (ins[15:12] != 4'hF) return npc;
    if (ins[25:22] == 4'h0 && ins[7:4] == 4'h9) return npc;
    if (ins[23:4] inside {20'h2FFF1, 20'h2FFF2, 20'h2FFF3})
      return ((ins[3:0] == 4'hF) ? pc + 32'd8 : regs_m[ins[3:0]]) & ~32'd1;
    c = {31'd0, regs_m[atnp_pkg::CpsrIdx][29]};
    a = (ins[19:16] == 4'hF) ? pc + 32'd8 : regs_m[ins[19:16]];
    if (ins[25]) begin
      imm = {24'd0, ins[7:0]};
      rot = {ins[11:8], 1'b0};
      b = (rot == 0) ? imm : (imm >> rot) | (imm << (32 - rot));
    end else begin
      b = shifted_op(ins, pc, c[0]);
    end
    case (ins[24:21])
      4'h0: return a & b;
      4'h1: return a ^ b;
      4'h2: return a - b;
      4'h3: return b - a;
      4'h4: return a + b;
      4'h5: return a + b + c;
      4'h6: return a - b + c;
      4'h7: return b - a + c;
      4'hC: return a | b;
      4'hD: return b;
      4'hE: return a & ~b;
      4'hF: return ~b;
      default: return npc;
    endcase
  endfunction

  // Evaluate one ARM word; returns the pending kind and the address
  function automatic void arm_next(logic [31:0] ins, output atnp_pkg::pend_e pk,
                                   output logic [31:0] val);
    logic [31:0] pc, base, off;
    logic        hit;
    pc = regs_m[atnp_pkg::PcIdx];
    val = pc + 32'd4;
    pk = atnp_pkg::PendNone;
    if (!cond_ok(ins[31:28])) begin
      hit = 1'b0;
      if (ins[31:28] == 4'hF)
        for (int i = 0; i < 7; i++)
          if ((ins & UNC_MSK[i]) == (UNC_PAT[i] & UNC_MSK[i])) hit = 1'b1;
      if (!hit) return;
    end
    case (ins[27:24])
      4'h1: begin
        if (!(ins[4] && ins[7] && ins[20] && ins[6:5] != 0 && ins[15:12] == 4'hF))
          val = alu_to_pc(ins, pc, pc + 32'd4);
      end
      4'h0, 4'h2, 4'h3: val = alu_to_pc(ins, pc, pc + 32'd4);
      4'h4, 4'h5, 4'h6, 4'h7: begin
        if (ins[20] && ins[15:12] == 4'hF && !ins[22]) begin
          base = (ins[19:16] == 4'hF) ? pc + 32'd8 : regs_m[ins[19:16]];
          off = ins[25] ? shifted_op(ins, pc, regs_m[atnp_pkg::CpsrIdx][29])
                        : {20'd0, ins[11:0]};
          if (!ins[23]) off = -off;
          if (ins[24]) base = base + off;
          val = base;
          pk = atnp_pkg::PendLdr;
        end
      end
      4'h8, 4'h9: begin
        if (ins[20] && ins[15]) begin
          off = 0;
          if (ins[23]) begin
            off = 4 * $countones(ins[14:0]);
            if (ins[24]) off = off + 4;
          end else if (ins[24]) begin
            off = -32'd4;
          end
          val = regs_m[ins[19:16]] + off;
          pk = atnp_pkg::PendLdm;
        end
      end
      4'hA, 4'hB: begin
        val = pc + 32'd8 + {{6{ins[23]}}, ins[23:0], 2'b00};
        if (ins[31:28] == 4'hF) val = val + {30'd0, ins[24], 1'b0};
      end
      default: ;
    endcase
  endfunction

  function automatic void thumb_next(logic [31:0] ins, output atnp_pkg::pend_e pk,
                                     output logic [31:0] val);
    logic [31:0] pc, npc, opd;
    pc = regs_m[atnp_pkg::PcIdx];
    npc = pc + 32'd2;
    pk = atnp_pkg::PendNone;
    if (ins[15:13] == 3'd7 && ins[12:11] != 0) begin
      npc = npc + 32'd2;
    end else begin
      case (ins[15:12])
        4'h4: begin
          opd = (ins[6:3] == 4'hF) ? pc + 32'd4 : regs_m[ins[6:3]];
          if (ins[11:8] == 4'h7) npc = opd;
          else if (ins[7] && (ins[11:0] & 12'hC07) == 12'h407) begin
            if (ins[9:8] == 2'd0) npc = pc + 32'd4 + opd;
            else if (ins[9:8] == 2'd2) npc = opd;
          end
        end
        4'hB: begin
          if (ins[11:8] == 4'hD) begin
            val = regs_m[atnp_pkg::SpIdx] + 4 * $countones(ins[7:0]);
            pk = atnp_pkg::PendPop;
            return;
          end
        end
        4'hD: begin
          if (ins[11:8] != 4'hF && cond_ok(ins[11:8]))
            npc = pc + 32'd4 + {{23{ins[7]}}, ins[7:0], 1'b0};
        end
        4'hE: begin
          if (!ins[11]) npc = pc + 32'd4 + {{20{ins[10]}}, ins[10:0], 1'b0};
        end
        default: ;
      endcase
    end
    val = npc & ~32'd1;
  endfunction

  // Advance the predictor by one accepted item
  task automatic predict_step(atnp_pkg::op_e op, logic [4:0] idx, logic [31:0] data,
                              logic [31:0] ins);
    npc_t            r;
    atnp_pkg::pend_e pk;
    logic [31:0]     v;
    case (op)
      atnp_pkg::OpWrite: if (idx < atnp_pkg::NumRegs) regs_m[idx] = data;
      atnp_pkg::OpEval: begin
        if (regs_m[atnp_pkg::CpsrIdx][5]) thumb_next(ins, pk, v);
        else arm_next(ins, pk, v);
        pend_m = pk;
        r.kind = (pk != atnp_pkg::PendNone);
        r.value = v;
        next_pc_q.push_back(r);
      end
      atnp_pkg::OpData: begin
        if (pend_m != atnp_pkg::PendNone) begin
          case (pend_m)
            atnp_pkg::PendLdr: v = data & 32'hFFFFFFFC;
            atnp_pkg::PendPop: v = data & ~32'd1;
            default: v = data;
          endcase
          pend_m = atnp_pkg::PendNone;
          r.kind = 1'b0;
          r.value = v;
          next_pc_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then predict
  task automatic send_item(atnp_pkg::op_e op, logic [4:0] idx, logic [31:0] data,
                           logic [31:0] ins);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ins, data, idx, op};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    predict_step(op, idx, data, ins);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (next_pc_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [4:0] idx, logic [31:0] v);
    send_item(atnp_pkg::OpWrite, idx, v, $urandom());
  endtask

  task automatic eval_ins(logic [31:0] ins);
    send_item(atnp_pkg::OpEval, 5'($urandom()), $urandom(), ins);
  endtask

  task automatic return_data(logic [31:0] d);
    send_item(atnp_pkg::OpData, 5'($urandom()), d, $urandom());
  endtask

  // Receiver: random stall, long hold-off on request; check each result
  always @(posedge clk_i) begin
    npc_t exp_r;
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (next_pc_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %08h", m_axis_tuser, m_axis_tdata);
      end else begin
        exp_r = next_pc_q.pop_front();
        if (exp_r.kind !== m_axis_tuser || exp_r.value !== m_axis_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d value %08h, got kind %0d value %08h",
                     exp_r.kind, exp_r.value, m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  // Fill every register so no evaluate reads an unwritten entry
  task automatic test_register_load();
    for (int i = 0; i < 15; i++) write_reg(5'(i), 32'h1000 * (i + 1) + 32'h10 * i);
    write_reg(atnp_pkg::PcIdx, 32'h0000_8000);
    write_reg(atnp_pkg::CpsrIdx, 32'h0000_0000);
  endtask

  task automatic test_arm_directed();
    eval_ins(32'hE1A0F001);            // mov pc, r1
    eval_ins(32'hE28FF008);            // add pc, pc, #8, plain immediate
    eval_ins(32'hE3A0F4FF);            // mov pc, rotated immediate
    eval_ins(32'hE1A0F311);            // register-shifted operand
    eval_ins(32'hE0A0F062);            // adc with rrx operand
    eval_ins(32'hE12FFF13);            // bx r3
    eval_ins(32'hE59FF004);            // ldr pc, [pc, #4]
    return_data(32'hFFFFFFFF);
    eval_ins(32'hE8BD8000);            // ldm sp!, {pc}
    return_data(32'h8000_0003);
    eval_ins(32'hEAFFFFFE);            // b to self
    eval_ins(32'hFB000001);            // blx immediate with H bit
    eval_ins(32'h0A000010);            // beq, failing condition
    eval_ins(32'hE15F0000);            // compare leaves pc+4
    write_reg(atnp_pkg::PcIdx, 32'hFFFF_FFFC);
    eval_ins(32'hE1E0F00F);            // mvn pc, pc at top of address space
  endtask

  task automatic test_thumb_directed();
    write_reg(atnp_pkg::CpsrIdx, 32'h4000_0020);
    eval_ins(32'h0000_4718);           // bx r3
    eval_ins(32'h0000_4487);           // add pc, r0
    eval_ins(32'h0000_46F7);           // mov pc, lr
    eval_ins(32'h0000_BD0F);           // pop {r0-r3, pc}
    return_data(32'h1234_5679);
    eval_ins(32'h0000_D0FE);           // beq taken
    eval_ins(32'h0000_DEFE);           // condition field 14
    eval_ins(32'h0000_E7FE);           // b to self
    eval_ins(32'hF800_F000);           // 32-bit prefix
    eval_ins(32'hFFFF_0000);           // plain instruction
  endtask

  task automatic test_odd_items();
    return_data(32'hDEAD_BEEF);        // data with nothing pending
    send_item(atnp_pkg::OpNone, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(5'd31, 32'hFFFF_FFFF);   // index out of range
    eval_ins(32'h0000_BD01);           // pop, then abandon by evaluating again
    eval_ins(32'h0000_BD80);
    write_reg(5'd2, 32'h0000_0040);    // write while a read is pending
    return_data(32'h0000_0000);
    write_reg(atnp_pkg::CpsrIdx, 32'h0000_0000);
  endtask

  function automatic logic [31:0] rand_arm();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0: begin r[27:26] = 2'b00; r[15:12] = 4'hF; end
      1: r = 32'h012FFF00 | (32'($urandom_range(1, 3)) << 4) | 32'($urandom_range(15));
      2: begin r[27:26] = 2'b01; r[20] = 1'b1; r[15:12] = 4'hF; r[22] = 1'b0; end
      3: begin r[27:25] = 3'b100; r[20] = 1'b1; r[15] = 1'b1; end
      4: r[27:25] = 3'b101;
      5: begin r[31:28] = 4'hF; return r; end
      default: return r;
    endcase
    r[31:28] = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'hE;
    return r;
  endfunction

  function automatic logic [31:0] rand_thumb();
    logic [15:0] h;
    h = $urandom();
    case ($urandom_range(7))
      0: h = 16'h4700 | {8'd0, h[7:0]};
      1: h = {6'b010001, h[9:8], 1'b1, h[6:3], 3'b111};
      2: h = {8'hBD, h[7:0]};
      3: h[15:12] = 4'hD;
      4: h[15:11] = 5'b11100;
      5: h[15:13] = 3'b111;
      default: ;
    endcase
    return {16'($urandom()), h};
  endfunction

  // Random sequences: up to two writes, an evaluate, usually a data return when a load is pending
  task automatic random_sequence();
    logic [31:0] c;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(9))
        0, 1: begin
          c = $urandom();
          c[5] = $urandom_range(1);
          write_reg(atnp_pkg::CpsrIdx, c);
        end
        2: write_reg(atnp_pkg::PcIdx, $urandom());
        3: write_reg(5'($urandom_range(17, 31)), $urandom());
        default: write_reg(5'($urandom_range(14)), $urandom());
      endcase
    end
    if ($urandom_range(19) == 0)
      send_item(atnp_pkg::OpNone, 5'($urandom()), $urandom(), $urandom());
    eval_ins(regs_m[atnp_pkg::CpsrIdx][5] ? rand_thumb() : rand_arm());
    if (pend_m != atnp_pkg::PendNone ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0))
      return_data($urandom());
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int n);
    int stop;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop = items_sent + n;
    while (items_sent < stop) random_sequence();
  endtask

  // Receiver holds off for a long stretch while evaluates keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_gen++;
    repeat (12) eval_ins(regs_m[atnp_pkg::CpsrIdx][5] ? rand_thumb() : rand_arm());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_load();
    test_arm_directed();
    test_thumb_directed();
    test_odd_items();
    wait_drained();
    test_backpressure();
    test_random(0, 0, 97);
    test_random(53, 0, 97);
    wait_drained();
    test_random(0, 53, 97);
    test_random(38, 38, 97);
    wait_drained();
    if (mismatches == 0 && next_pc_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/atnp_pkg.sv
rtl/atnp_ram.sv
rtl/arm_thumb_next_pc_unit.sv
dv/tb.sv
